### sv/sfep_pkg.sv
// Shared types, codes and helpers for the scale frame event parser.
package sfep_pkg;

  typedef enum logic [3:0] {
    PH_HUNT_A,
    PH_HUNT_B,
    PH_TYPE,
    PH_LEN,
    PH_BODY
  } phase_t;

  localparam logic [7:0] HDR_FIRST  = 8'hEF;
  localparam logic [7:0] HDR_SECOND = 8'hDD;
  localparam logic [7:0] SIGN_MASK  = 8'h02;

  localparam logic [7:0] KIND_SYSTEM = 8'd0;
  localparam logic [7:0] KIND_INFO   = 8'd7;
  localparam logic [7:0] KIND_STATUS = 8'd8;
  localparam logic [7:0] KIND_EVENT  = 8'd12;

  localparam logic [7:0] EV_NONE    = 8'd0;
  localparam logic [7:0] EV_WEIGHT  = 8'd5;
  localparam logic [7:0] EV_BATTERY = 8'd6;
  localparam logic [7:0] EV_TIMER   = 8'd7;
  localparam logic [7:0] EV_KEY     = 8'd8;
  localparam logic [7:0] EV_ACK     = 8'd11;

  localparam logic [1:0] UPD_WEIGHT  = 2'd0;
  localparam logic [1:0] UPD_BATTERY = 2'd1;
  localparam logic [1:0] UPD_TIMER   = 2'd2;

  localparam int EV_BYTES = 6;

  typedef struct packed {
    logic [1:0]  update_kind;
    logic [15:0] weight_magnitude;
    logic        weight_negative;
    logic [2:0]  weight_decimals;
    logic [7:0]  battery_level;
    logic [7:0]  timer_minutes;
    logic [7:0]  timer_seconds;
    logic [7:0]  timer_fraction;
  } result_t;

  // Bytes that follow a sub-event code; 0 marks an unknown code.
  function automatic logic [2:0] sub_len(input logic [7:0] code);
    logic [2:0] n;
    n = 3'd0;
    case (code) inside
      EV_WEIGHT:          n = 3'd6;
      EV_BATTERY, EV_KEY: n = 3'd1;
      EV_TIMER:           n = 3'd3;
      EV_ACK:             n = 3'd2;
      default:            n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

### sv/sfep_in_reg.sv
// Input register: holds one received byte until the parser steps on it.
module sfep_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_q
);

  logic accept;
  logic byte_valid_next;

  assign rx_stall = byte_valid && !take;
  assign accept   = rx_valid && !rx_stall;

  always_comb begin
    byte_valid_next = byte_valid;
    if (accept) begin
      byte_valid_next = 1'b1;
    end else if (take) begin
      byte_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      byte_valid <= byte_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= rx_byte;
    end
  end

endmodule

### sv/sfep_parser.sv
// Frame parser: per-byte state step and sub-event decode.
module sfep_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           b,
  output logic                 produced,
  output sfep_pkg::result_t    res
);

  sfep_pkg::phase_t phase, phase_next;
  logic [7:0] message_kind, message_kind_next;
  logic [8:0] bytes_remaining, bytes_remaining_next;
  logic [7:0] payload_position, payload_position_next;
  logic [7:0] event_code, event_code_next;
  logic [2:0] event_fill, event_fill_next;
  logic       events_aborted, events_aborted_next;
  logic [7:0] event_bytes [sfep_pkg::EV_BYTES];
  logic [7:0] view [sfep_pkg::EV_BYTES];

  logic       wr_en;
  logic [8:0] left;
  logic [2:0] n_code;
  logic [2:0] n_cur;
  logic [2:0] fill_inc;

  // current sub-event bytes with this cycle's byte merged in
  always_comb begin
    for (int i = 0; i < sfep_pkg::EV_BYTES; i++) begin
      view[i] = (wr_en && event_fill == 3'(i)) ? b : event_bytes[i];
    end
  end

  always_comb begin
    phase_next            = phase;
    message_kind_next     = message_kind;
    bytes_remaining_next  = bytes_remaining;
    payload_position_next = payload_position;
    event_code_next       = event_code;
    event_fill_next       = event_fill;
    events_aborted_next   = events_aborted;
    wr_en                 = 1'b0;
    produced              = 1'b0;
    res                   = '0;
    left                  = bytes_remaining - 9'd3;
    n_code                = sfep_pkg::sub_len(b);
    n_cur                 = sfep_pkg::sub_len(event_code);
    fill_inc              = event_fill + 3'd1;
    if (step) begin
      unique case (phase)
        sfep_pkg::PH_HUNT_B: begin
          if (b == sfep_pkg::HDR_SECOND) begin
            phase_next = sfep_pkg::PH_TYPE;
          end else if (b != sfep_pkg::HDR_FIRST) begin
            phase_next = sfep_pkg::PH_HUNT_A;
          end
        end
        sfep_pkg::PH_TYPE: begin
          message_kind_next     = b;
          payload_position_next = 8'd0;
          event_code_next       = sfep_pkg::EV_NONE;
          event_fill_next       = 3'd0;
          events_aborted_next   = 1'b0;
          if (b == sfep_pkg::KIND_INFO || b == sfep_pkg::KIND_STATUS ||
              b == sfep_pkg::KIND_EVENT) begin
            phase_next = sfep_pkg::PH_LEN;
          end else begin
            bytes_remaining_next = (b == sfep_pkg::KIND_SYSTEM) ? 9'd4 : 9'd2;
            phase_next           = sfep_pkg::PH_BODY;
          end
        end
        sfep_pkg::PH_LEN: begin
          // length counts itself; zero reads as one; plus two checksum bytes
          bytes_remaining_next = (b == 8'd0) ? 9'd2 : ({1'b0, b} + 9'd1);
          phase_next           = sfep_pkg::PH_BODY;
        end
        sfep_pkg::PH_BODY: begin
          if (bytes_remaining > 9'd2) begin
            if (message_kind == sfep_pkg::KIND_INFO && payload_position == 8'd4) begin
              produced          = 1'b1;
              res.update_kind   = sfep_pkg::UPD_BATTERY;
              res.battery_level = b;
            end else if (message_kind == sfep_pkg::KIND_EVENT && !events_aborted) begin
              if (event_code == sfep_pkg::EV_NONE) begin
                // code byte: unknown or truncated sub-event skips the rest
                if (n_code == 3'd0 || {6'd0, n_code} > left) begin
                  events_aborted_next = 1'b1;
                end else begin
                  event_code_next = b;
                  event_fill_next = 3'd0;
                end
              end else begin
                wr_en           = (event_fill < 3'd6);
                event_fill_next = fill_inc;
                if (fill_inc >= n_cur) begin
                  event_code_next = sfep_pkg::EV_NONE;
                  event_fill_next = 3'd0;
                  case (event_code)
                    sfep_pkg::EV_WEIGHT: begin
                      produced             = 1'b1;
                      res.update_kind      = sfep_pkg::UPD_WEIGHT;
                      res.weight_magnitude = {view[1], view[0]};
                      res.weight_negative  = |(view[5] & sfep_pkg::SIGN_MASK);
                      res.weight_decimals  = (view[4] >= 8'd1 && view[4] <= 8'd4) ?
                                             view[4][2:0] : 3'd0;
                    end
                    sfep_pkg::EV_BATTERY: begin
                      produced          = 1'b1;
                      res.update_kind   = sfep_pkg::UPD_BATTERY;
                      res.battery_level = view[0];
                    end
                    sfep_pkg::EV_TIMER: begin
                      produced           = 1'b1;
                      res.update_kind    = sfep_pkg::UPD_TIMER;
                      res.timer_minutes  = view[0];
                      res.timer_seconds  = view[1];
                      res.timer_fraction = view[2];
                    end
                    default: begin
                    end
                  endcase
                end
              end
            end
            payload_position_next = payload_position + 8'd1;
          end
          if (bytes_remaining != 9'd0) begin
            bytes_remaining_next = bytes_remaining - 9'd1;
          end
          if (bytes_remaining_next == 9'd0) begin
            phase_next = sfep_pkg::PH_HUNT_A;
          end
        end
        default: begin
          phase_next = (b == sfep_pkg::HDR_FIRST) ? sfep_pkg::PH_HUNT_B : sfep_pkg::PH_HUNT_A;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= sfep_pkg::PH_HUNT_A;
      message_kind     <= 8'd0;
      bytes_remaining  <= 9'd0;
      payload_position <= 8'd0;
      event_code       <= sfep_pkg::EV_NONE;
      event_fill       <= 3'd0;
      events_aborted   <= 1'b0;
    end else begin
      phase            <= phase_next;
      message_kind     <= message_kind_next;
      bytes_remaining  <= bytes_remaining_next;
      payload_position <= payload_position_next;
      event_code       <= event_code_next;
      event_fill       <= event_fill_next;
      events_aborted   <= events_aborted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      event_bytes[event_fill] <= b;
    end
  end

  a_body_has_count: assert property (@(posedge clk) disable iff (rst)
    phase == sfep_pkg::PH_BODY |-> bytes_remaining != 9'd0)
    else $error("body phase with nothing left");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    event_fill <= 3'd5)
    else $error("sub-event fill out of range");

  a_code_in_event: assert property (@(posedge clk) disable iff (rst)
    event_code != sfep_pkg::EV_NONE |->
      (message_kind == sfep_pkg::KIND_EVENT && !events_aborted))
    else $error("sub-event open outside event frame");

  a_result_in_body: assert property (@(posedge clk) disable iff (rst)
    produced |-> (step && phase == sfep_pkg::PH_BODY && bytes_remaining > 9'd2))
    else $error("update outside payload");

endmodule

### sv/sfep_out_reg.sv
// Result register: holds one update until the consumer takes it.
module sfep_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sfep_pkg::result_t res,
  output logic              free,
  output logic              upd_valid,
  input  logic              upd_stall,
  output sfep_pkg::result_t res_q
);

  logic upd_valid_next;

  assign free = !upd_valid || !upd_stall;

  always_comb begin
    upd_valid_next = upd_valid;
    if (load) begin
      upd_valid_next = 1'b1;
    end else if (upd_valid && !upd_stall) begin
      upd_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid <= 1'b0;
    end else begin
      upd_valid <= upd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule

### sv/scale_frame_event_parser.sv
// Top level of the scale frame event parser: input register, parser, result register.
// Throughput: one received byte per cycle, sustained, while updates are taken.
// Path: a byte held in the input register is parsed on the step that takes it, which waits
//   until the result register is free; an update it completes is loaded there and offered.
// The rate is set by the combinational parser step between the two registers.
// Reset (rst, synchronous, active high): hunts for a header, no update pending.
module scale_frame_event_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        upd_valid,
  input  logic        upd_stall,
  output logic [1:0]  update_kind,
  output logic [15:0] weight_magnitude,
  output logic        weight_negative,
  output logic [2:0]  weight_decimals,
  output logic [7:0]  battery_level,
  output logic [7:0]  timer_minutes,
  output logic [7:0]  timer_seconds,
  output logic [7:0]  timer_fraction
);

  // held byte and its valid flag
  logic              byte_valid;
  logic [7:0]        byte_q;
  // parser steps when a byte is held and the result register can take an update
  logic              take;
  logic              out_free;
  logic              produced;
  sfep_pkg::result_t res;
  sfep_pkg::result_t res_q;

  assign take = byte_valid && out_free;

  sfep_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  sfep_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (take),
    .b        (byte_q),
    .produced (produced),
    .res      (res)
  );

  // update loads only on a parser step that completes one
  sfep_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && produced),
    .res       (res),
    .free      (out_free),
    .upd_valid (upd_valid),
    .upd_stall (upd_stall),
    .res_q     (res_q)
  );

  assign update_kind      = res_q.update_kind;
  assign weight_magnitude = res_q.weight_magnitude;
  assign weight_negative  = res_q.weight_negative;
  assign weight_decimals  = res_q.weight_decimals;
  assign battery_level    = res_q.battery_level;
  assign timer_minutes    = res_q.timer_minutes;
  assign timer_seconds    = res_q.timer_seconds;
  assign timer_fraction   = res_q.timer_fraction;

endmodule
